@@ sv/mri_pkg.sv @@
// ----------------------------------------------------------------------------
// mri_pkg
// Types and codes shared by the rendezvous message passing block and its
// checker.
// ----------------------------------------------------------------------------
package mri_pkg;

  localparam int NUM_PROCS = 8;
  localparam int PID_W     = 3;
  localparam int CODE_W    = 4;
  localparam int CNT_W     = 4;

  // request functions
  localparam logic [1:0] FN_SEND   = 2'd0;
  localparam logic [1:0] FN_RECV   = 2'd1;
  localparam logic [1:0] FN_NOTICE = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // process modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_RECV = 2'd2;

  // peer and link codes
  localparam logic [CODE_W-1:0] CODE_ANY  = 4'd8;
  localparam logic [CODE_W-1:0] CODE_INT  = 4'd9;
  localparam logic [CODE_W-1:0] CODE_NONE = 4'd15;
  localparam logic [CODE_W-1:0] CODE_IMSG = 4'd8;

  // result status
  localparam logic [2:0] ST_COPIED  = 3'd0;
  localparam logic [2:0] ST_BLOCKED = 3'd1;
  localparam logic [2:0] ST_INTR    = 3'd2;
  localparam logic [2:0] ST_REJECT  = 3'd3;
  localparam logic [2:0] ST_LATCHED = 3'd4;

  typedef struct packed {
    logic [1:0]        func;
    logic [PID_W-1:0]  caller;
    logic [CODE_W-1:0] peer;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CODE_W-1:0] copy_from;
    logic [PID_W-1:0]  copy_to;
    logic              woken_valid;
    logic [PID_W-1:0]  woken_pid;
  } rsp_t;

  // one process table entry
  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] send_target;
    logic [CODE_W-1:0] recv_source;
    logic              int_pending;
    logic [CODE_W-1:0] queue_head;
    logic [CODE_W-1:0] queue_link;
  } ent_t;

  localparam ent_t ENT_RESET = '{mode: MODE_IDLE, send_target: CODE_NONE,
                                 recv_source: CODE_NONE, int_pending: 1'b0,
                                 queue_head: CODE_NONE, queue_link: CODE_NONE};

  function automatic logic is_pid(input logic [CODE_W-1:0] v);
    return v < CODE_W'(NUM_PROCS);
  endfunction

endpackage

@@ sv/message_rendezvous_ipc.sv @@
// ----------------------------------------------------------------------------
// message_rendezvous_ipc
// Rendezvous message passing controller over a table of processes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one request beat (func, caller, peer); out_* returns one
//   result beat per request (status, copy source and target, woken process).
//   Both channels are valid/ready.
//   The process table sits in one synchronous memory (one read, one write
//   per cycle, read data registered). Requests run one at a time:
//   - rejected on the request fields alone: no table access
//   - interrupt notice: one read and one write of the caller's entry
//   - send: caller read, up to 8 chain reads and up to 9 queue tail reads
//   - receive from a named sender: a walk over the caller's queue
//   The deadlock chain walk and the queue walks take one table read per
//   step. in_ready is high while no request is in flight; a
//   result held by a stalled receiver does not block the next request, but
//   that request's result waits until the held beat is taken.
//   Reset clears the per-entry valid bits at once: every process reads as
//   idle with empty queue, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module message_rendezvous_ipc (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mri_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mri_pkg::rsp_t out_data
);
  import mri_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDC    = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_SDEC   = 4'd3;
  localparam logic [3:0] S_TAIL   = 4'd4;
  localparam logic [3:0] S_WRC    = 4'd5;
  localparam logic [3:0] S_RDS    = 4'd6;
  localparam logic [3:0] S_MWALK  = 4'd7;
  localparam logic [3:0] S_MRD    = 4'd8;
  localparam logic [3:0] S_RDF    = 4'd9;
  localparam logic [3:0] S_UNLINK = 4'd10;
  localparam logic [3:0] S_WRF    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  // process table
  ent_t             mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] vld_r;
  ent_t             rd_data_r;
  logic             rd_vld_r;
  ent_t             rd_ent;
  logic             mem_re, mem_we;
  logic [PID_W-1:0] mem_raddr, mem_waddr;
  ent_t             mem_wdata;

  logic [3:0]        state_r, state_nxt;
  req_t              req_r, req_nxt;
  ent_t              c_ent_r, c_ent_nxt;
  ent_t              x_ent_r, x_ent_nxt;
  ent_t              prev_ent_r, prev_ent_nxt;
  logic [CODE_W-1:0] p_r, p_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  rsp_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_data_r, out_data_nxt;

  logic [CODE_W-1:0] c_code;
  logic              early_rej;
  rsp_t              rsp_rej;
  rsp_t              rsp_blk;
  ent_t              w;

  // table write and registered read; unwritten entries read as reset
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
      rd_vld_r  <= vld_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_waddr] <= 1'b1;
    end
  end

  assign rd_ent = rd_vld_r ? rd_data_r : ENT_RESET;

  assign c_code   = {1'b0, req_r.caller};
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    rsp_rej        = '0;
    rsp_rej.status = ST_REJECT;
    rsp_blk        = '0;
    rsp_blk.status = ST_BLOCKED;
    early_rej = (in_data.func == FN_UNUSED) ||
                ((in_data.func != FN_NOTICE) && (in_data.peer == {1'b0, in_data.caller})) ||
                ((in_data.func == FN_SEND) && !is_pid(in_data.peer)) ||
                ((in_data.func == FN_RECV) && !is_pid(in_data.peer) &&
                 (in_data.peer != CODE_ANY) && (in_data.peer != CODE_INT));
  end

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    c_ent_nxt     = c_ent_r;
    x_ent_nxt     = x_ent_r;
    prev_ent_nxt  = prev_ent_r;
    p_nxt         = p_r;
    prev_nxt      = prev_r;
    n_nxt         = n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_raddr     = req_r.caller;
    mem_we        = 1'b0;
    mem_waddr     = req_r.caller;
    mem_wdata     = c_ent_r;
    w             = c_ent_r;

    // drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          if (early_rej) begin
            res_nxt   = rsp_rej;
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = in_data.caller;
            state_nxt = S_RDC;
          end
        end
      end

      S_RDC: begin
        c_ent_nxt = rd_ent;
        w         = rd_ent;
        if (req_r.func == FN_NOTICE) begin
          mem_we = 1'b1;
          if ((rd_ent.mode == MODE_RECV) &&
              ((rd_ent.recv_source == CODE_INT) || (rd_ent.recv_source == CODE_ANY))) begin
            w.mode        = MODE_IDLE;
            w.recv_source = CODE_NONE;
            w.send_target = CODE_NONE;
            w.int_pending = 1'b0;
            res_nxt             = '0;
            res_nxt.status      = ST_INTR;
            res_nxt.copy_from   = CODE_IMSG;
            res_nxt.copy_to     = req_r.caller;
            res_nxt.woken_valid = 1'b1;
            res_nxt.woken_pid   = req_r.caller;
          end else begin
            w.int_pending  = 1'b1;
            res_nxt        = '0;
            res_nxt.status = ST_LATCHED;
          end
          mem_wdata = w;
          state_nxt = S_DONE;
        end else if (rd_ent.mode != MODE_IDLE) begin
          res_nxt   = rsp_rej;
          state_nxt = S_DONE;
        end else if (req_r.func == FN_SEND) begin
          mem_re    = 1'b1;
          mem_raddr = req_r.peer[PID_W-1:0];
          p_nxt     = req_r.peer;
          n_nxt     = '0;
          state_nxt = S_WALK;
        end else if (rd_ent.int_pending &&
                     ((req_r.peer == CODE_ANY) || (req_r.peer == CODE_INT))) begin
          w.int_pending     = 1'b0;
          mem_we            = 1'b1;
          mem_wdata         = w;
          res_nxt           = '0;
          res_nxt.status    = ST_INTR;
          res_nxt.copy_from = CODE_IMSG;
          res_nxt.copy_to   = req_r.caller;
          state_nxt         = S_DONE;
        end else if (req_r.peer == CODE_ANY && is_pid(rd_ent.queue_head)) begin
          p_nxt     = rd_ent.queue_head;
          mem_re    = 1'b1;
          mem_raddr = rd_ent.queue_head[PID_W-1:0];
          state_nxt = S_RDF;
        end else if (req_r.peer == CODE_INT || req_r.peer == CODE_ANY) begin
          w.mode        = MODE_RECV;
          w.recv_source = req_r.peer;
          mem_we        = 1'b1;
          mem_wdata     = w;
          res_nxt       = rsp_blk;
          state_nxt     = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = req_r.peer[PID_W-1:0];
          state_nxt = S_RDS;
        end
      end

      // follow send targets from the destination looking for the caller
      S_WALK: begin
        if (n_r == '0) begin
          x_ent_nxt = rd_ent;
        end
        if ((rd_ent.mode != MODE_SEND) || !is_pid(rd_ent.send_target)) begin
          state_nxt = S_SDEC;
        end else if (rd_ent.send_target == c_code) begin
          res_nxt   = rsp_rej;
          state_nxt = S_DONE;
        end else if (n_r == CNT_W'(NUM_PROCS - 1)) begin
          state_nxt = S_SDEC;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_ent.send_target[PID_W-1:0];
          n_nxt     = n_r + 1'b1;
          state_nxt = S_WALK;
        end
      end

      // hand over to a waiting receiver, or queue the caller
      S_SDEC: begin
        w = x_ent_r;
        if ((x_ent_r.mode == MODE_RECV) &&
            ((x_ent_r.recv_source == c_code) || (x_ent_r.recv_source == CODE_ANY))) begin
          w.mode        = MODE_IDLE;
          w.recv_source = CODE_NONE;
          mem_we        = 1'b1;
          mem_waddr     = req_r.peer[PID_W-1:0];
          mem_wdata     = w;
          res_nxt             = '0;
          res_nxt.status      = ST_COPIED;
          res_nxt.copy_from   = c_code;
          res_nxt.copy_to     = req_r.peer[PID_W-1:0];
          res_nxt.woken_valid = 1'b1;
          res_nxt.woken_pid   = req_r.peer[PID_W-1:0];
          state_nxt = S_DONE;
        end else if (is_pid(x_ent_r.queue_head)) begin
          p_nxt     = x_ent_r.queue_head;
          n_nxt     = '0;
          mem_re    = 1'b1;
          mem_raddr = x_ent_r.queue_head[PID_W-1:0];
          state_nxt = S_TAIL;
        end else begin
          w.queue_head = c_code;
          mem_we       = 1'b1;
          mem_waddr    = req_r.peer[PID_W-1:0];
          mem_wdata    = w;
          state_nxt    = S_WRC;
        end
      end

      // advance to the queue tail and link the caller behind it
      S_TAIL: begin
        if ((n_r < CNT_W'(NUM_PROCS)) && is_pid(rd_ent.queue_link)) begin
          p_nxt     = rd_ent.queue_link;
          n_nxt     = n_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = rd_ent.queue_link[PID_W-1:0];
        end else begin
          w            = rd_ent;
          w.queue_link = c_code;
          mem_we       = 1'b1;
          mem_waddr    = p_r[PID_W-1:0];
          mem_wdata    = w;
          state_nxt    = S_WRC;
        end
      end

      S_WRC: begin
        w.mode        = MODE_SEND;
        w.send_target = req_r.peer;
        w.queue_link  = CODE_NONE;
        mem_we        = 1'b1;
        mem_wdata     = w;
        res_nxt       = rsp_blk;
        state_nxt     = S_DONE;
      end

      // named sender: check it targets the caller
      S_RDS: begin
        x_ent_nxt = rd_ent;
        if ((rd_ent.mode == MODE_SEND) && (rd_ent.send_target == c_code)) begin
          p_nxt     = c_ent_r.queue_head;
          prev_nxt  = CODE_NONE;
          n_nxt     = '0;
          state_nxt = S_MWALK;
        end else begin
          w.mode        = MODE_RECV;
          w.recv_source = req_r.peer;
          mem_we        = 1'b1;
          mem_wdata     = w;
          res_nxt       = rsp_blk;
          state_nxt     = S_DONE;
        end
      end

      // search the caller's queue for the named sender
      S_MWALK: begin
        if ((n_r < CNT_W'(NUM_PROCS)) && is_pid(p_r)) begin
          if (p_r == req_r.peer) begin
            state_nxt = S_UNLINK;
          end else begin
            prev_nxt  = p_r;
            mem_re    = 1'b1;
            mem_raddr = p_r[PID_W-1:0];
            state_nxt = S_MRD;
          end
        end else begin
          state_nxt = S_WRF;
        end
      end

      S_MRD: begin
        prev_ent_nxt = rd_ent;
        p_nxt        = rd_ent.queue_link;
        n_nxt        = n_r + 1'b1;
        state_nxt    = S_MWALK;
      end

      // any sender: take the queue head
      S_RDF: begin
        x_ent_nxt = rd_ent;
        prev_nxt  = CODE_NONE;
        state_nxt = S_UNLINK;
      end

      // unlink the sender from the caller's queue
      S_UNLINK: begin
        mem_we = 1'b1;
        if (is_pid(prev_r)) begin
          w            = prev_ent_r;
          w.queue_link = x_ent_r.queue_link;
          mem_waddr    = prev_r[PID_W-1:0];
        end else begin
          w.queue_head = x_ent_r.queue_link;
        end
        mem_wdata = w;
        state_nxt = S_WRF;
      end

      // release the sender
      S_WRF: begin
        w             = x_ent_r;
        w.queue_link  = CODE_NONE;
        w.send_target = CODE_NONE;
        w.mode        = MODE_IDLE;
        mem_we        = 1'b1;
        mem_waddr     = (req_r.peer == CODE_ANY) ? p_r[PID_W-1:0] : req_r.peer[PID_W-1:0];
        mem_wdata     = w;
        res_nxt             = '0;
        res_nxt.status      = ST_COPIED;
        res_nxt.copy_from   = {1'b0, mem_waddr};
        res_nxt.copy_to     = req_r.caller;
        res_nxt.woken_valid = 1'b1;
        res_nxt.woken_pid   = mem_waddr;
        state_nxt = S_DONE;
      end

      // hold until the result register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    c_ent_r    <= c_ent_nxt;
    x_ent_r    <= x_ent_nxt;
    prev_ent_r <= prev_ent_nxt;
    p_r        <= p_nxt;
    prev_r     <= prev_nxt;
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ sv/mri_checker.sv @@
// ----------------------------------------------------------------------------
// mri_checker
// Port-level assertions for the rendezvous message passing block.
// ----------------------------------------------------------------------------
module mri_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input mri_pkg::rsp_t out_data
);
  import mri_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // no copy fields unless a copy is reported
  a_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_COPIED) && (out_data.status != ST_INTR)
    |-> (out_data.copy_from == '0) && (out_data.copy_to == '0))
    else $error("copy fields set without a copy");

  // interrupt delivery copies the interrupt message
  a_intr_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_INTR) |-> (out_data.copy_from == CODE_IMSG))
    else $error("interrupt delivery with wrong source");

  // no wakeup pid without a wakeup
  a_woken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.woken_valid |-> (out_data.woken_pid == '0))
    else $error("woken pid set without wakeup");

endmodule

bind message_rendezvous_ipc mri_checker u_mri_checker (.*);
